// ----- rtl/isq_pkg.sv -----
package isq_pkg;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;
  localparam logic [2:0] MODE_FIND   = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]        mode;
    logic [6:0]        position;
    logic signed [63:0] data_value;
  } isq_in_t;

  typedef struct packed {
    logic signed [63:0] read_value;
    logic [5:0]        found_index;
    logic [6:0]        count;
    logic [2:0]        status;
  } isq_out_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_POS,
    IDX_CNT,
    IDX_INC,
    IDX_DEC
  } isq_idx_op_t;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_M1,
    RA_IDX_P1
  } isq_rd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } isq_cnt_op_t;

  typedef struct packed {
    logic        load_req;
    isq_idx_op_t idx_op;
    logic        rd_en;
    isq_rd_sel_t rd_sel;
    logic        wr_en;
    logic        wr_from_ram;
    isq_cnt_op_t cnt_op;
    logic        cap_rv;
    logic        cap_fi;
    logic        set_st;
    logic [2:0]  st_code;
    logic        load_out;
  } isq_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] check_st;
    logic       idx_gt_pos;
    logic       idx_p1_lt_cnt;
    logic       idx_lt_cnt;
    logic       match;
  } isq_sts_t;

endpackage

// ----- rtl/isq_ram.sv -----
module isq_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/isq_dp.sv -----
module isq_dp import isq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  isq_in_t  in_data,
  input  isq_cmd_t cmd,
  output isq_sts_t sts,
  output isq_out_t out_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW + 1 : 8;

  isq_in_t           req_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic signed [63:0] rv_r;
  logic [CW-1:0]     fi_r;
  logic [2:0]        st_r;
  isq_out_t          out_r;

  logic [CW-1:0]     idx_m1, idx_p1;
  logic [CMPW-1:0]   pos_x, cnt_x, idx_x, idx_p1_x;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [63:0]       rd_data, wr_data;
  logic [2:0]        check_st;

  assign idx_m1   = idx_r - CW'(1);
  assign idx_p1   = idx_r + CW'(1);
  assign pos_x    = CMPW'(req_r.position);
  assign cnt_x    = CMPW'(cnt_r);
  assign idx_x    = CMPW'(idx_r);
  assign idx_p1_x = idx_x + CMPW'(1);

  // Errors that are known before any entry is touched.
  always_comb begin
    check_st = ST_OK;
    unique case (req_r.mode)
      MODE_APPEND: begin
        if (cnt_x >= CMPW'(DEPTH)) check_st = ST_FULL;
      end
      MODE_REMOVE: begin
        if (cnt_r == '0) check_st = ST_EMPTY;
      end
      MODE_INSERT: begin
        if (pos_x > cnt_x) check_st = ST_RANGE;
        else if (cnt_x >= CMPW'(DEPTH)) check_st = ST_FULL;
      end
      MODE_DELETE, MODE_READ: begin
        if (cnt_r == '0) check_st = ST_EMPTY;
        else if (pos_x >= cnt_x) check_st = ST_RANGE;
      end
      default: check_st = ST_OK;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RA_IDX_M1: rd_addr = idx_m1[AW-1:0];
      RA_IDX_P1: rd_addr = idx_p1[AW-1:0];
      default:   rd_addr = idx_r[AW-1:0];
    endcase
  end

  assign wr_addr = idx_r[AW-1:0];
  assign wr_data = cmd.wr_from_ram ? rd_data : req_r.data_value;

  isq_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO: idx_nxt = '0;
      IDX_POS:  idx_nxt = CW'(req_r.position);
      IDX_CNT:  idx_nxt = cnt_r;
      IDX_INC:  idx_nxt = idx_p1;
      IDX_DEC:  idx_nxt = idx_m1;
      default:  idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + CW'(1);
      CNT_DEC: cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_req) begin
      req_r <= in_data;
      rv_r  <= '0;
      fi_r  <= '0;
      st_r  <= ST_OK;
    end else begin
      if (cmd.cap_rv) rv_r <= rd_data;
      if (cmd.cap_fi) fi_r <= idx_r;
      if (cmd.set_st) st_r <= cmd.st_code;
    end
    if (cmd.load_out) begin
      out_r.read_value  <= rv_r;
      out_r.found_index <= 6'(fi_r);
      out_r.count       <= 7'(cnt_r);
      out_r.status      <= st_r;
    end
  end

  assign sts.mode          = req_r.mode;
  assign sts.check_st      = check_st;
  assign sts.idx_gt_pos    = idx_x > pos_x;
  assign sts.idx_p1_lt_cnt = idx_p1_x < cnt_x;
  assign sts.idx_lt_cnt    = idx_x < cnt_x;
  assign sts.match         = rd_data == req_r.data_value;
  assign out_data          = out_r;

endmodule

// ----- rtl/isq_ctrl.sv -----
module isq_ctrl import isq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  isq_sts_t sts,
  output isq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_STEP,
    S_USE,
    S_WRITE,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   shift_r, shift_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.idx_op    = IDX_HOLD;
    cmd.rd_sel    = RA_IDX;
    cmd.cnt_op    = CNT_HOLD;
    cmd.st_code   = ST_OK;
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          shift_nxt    = 1'b0;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.check_st != ST_OK) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = sts.check_st;
          state_nxt   = S_FIN;
        end else begin
          unique case (sts.mode)
            MODE_APPEND: begin
              cmd.idx_op = IDX_CNT;
              state_nxt  = S_WRITE;
            end
            MODE_REMOVE, MODE_INSERT: begin
              cmd.idx_op = IDX_CNT;
              state_nxt  = S_STEP;
            end
            MODE_DELETE, MODE_READ: begin
              cmd.idx_op = IDX_POS;
              state_nxt  = S_STEP;
            end
            MODE_FIND: begin
              cmd.idx_op = IDX_ZERO;
              state_nxt  = S_STEP;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_STEP: begin
        unique case (sts.mode)
          MODE_REMOVE: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_IDX_M1;
            state_nxt  = S_USE;
          end
          MODE_INSERT: begin
            if (sts.idx_gt_pos) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_IDX_M1;
              state_nxt  = S_USE;
            end else begin
              state_nxt = S_WRITE;
            end
          end
          MODE_DELETE: begin
            if (!shift_r) begin
              cmd.rd_en = 1'b1;
              state_nxt = S_USE;
            end else if (sts.idx_p1_lt_cnt) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_IDX_P1;
              state_nxt  = S_USE;
            end else begin
              cmd.cnt_op = CNT_DEC;
              state_nxt  = S_FIN;
            end
          end
          MODE_FIND: begin
            if (sts.idx_lt_cnt) begin
              cmd.rd_en = 1'b1;
              state_nxt = S_USE;
            end else begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_NOTFOUND;
              state_nxt   = S_FIN;
            end
          end
          default: begin
            cmd.rd_en = 1'b1;
            state_nxt = S_USE;
          end
        endcase
      end
      S_USE: begin
        unique case (sts.mode)
          MODE_REMOVE: begin
            cmd.cap_rv = 1'b1;
            cmd.cnt_op = CNT_DEC;
            state_nxt  = S_FIN;
          end
          MODE_INSERT: begin
            // Move the entry below up by one place.
            cmd.wr_en       = 1'b1;
            cmd.wr_from_ram = 1'b1;
            cmd.idx_op      = IDX_DEC;
            state_nxt       = S_STEP;
          end
          MODE_DELETE: begin
            if (!shift_r) begin
              cmd.cap_rv = 1'b1;
              shift_nxt  = 1'b1;
            end else begin
              cmd.wr_en       = 1'b1;
              cmd.wr_from_ram = 1'b1;
              cmd.idx_op      = IDX_INC;
            end
            state_nxt = S_STEP;
          end
          MODE_FIND: begin
            if (sts.match) begin
              cmd.cap_fi = 1'b1;
              state_nxt  = S_FIN;
            end else begin
              cmd.idx_op = IDX_INC;
              state_nxt  = S_STEP;
            end
          end
          default: begin
            cmd.cap_rv = 1'b1;
            state_nxt  = S_FIN;
          end
        endcase
      end
      S_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.cnt_op = CNT_INC;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        // The output register takes the result once the previous item has gone.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shift_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/indexed_sequence_store.sv -----
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     isq_in_t  (mode, position, data_value)
// out_      output     out_valid / out_ready   isq_out_t (read_value, found_index, count,
//                                                         status)
//
// A refused item or an undefined mode goes from the check state straight to the final
// state, which loads the output register; an append writes one entry, a read or remove
// reads one, an insert or delete moves entries one place at a time, and a find compares
// entries in turn until a hit or the end of the count. The single read port of the entry
// RAM and its registered read give each moved or compared entry a step state and a use
// state, and the next item is accepted only once the controller is back in idle.
// Reset clears the count and the handshake state; the entries need no clearing.
// A new item is accepted while the previous result waits in the output register, and
// a finished item waits in the final state until out_ready lets the older result go.
module indexed_sequence_store import isq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  isq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output isq_out_t out_data
);

  isq_cmd_t cmd;
  isq_sts_t sts;

  isq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  isq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule
